// ===== src/mcfc_pkg.sv =====
// Shared constants for the 2D Mohr-Coulomb failure check.
// Register map and configuration port sizes; no dependencies.
package mcfc_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_IDX_LSB = 3;
  localparam int CFG_IDX_W   = CFG_ADDR_W - CFG_IDX_LSB;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_COHESION = 3'd0;
  localparam reg_idx_t REG_SLOPE    = 3'd1;
  localparam reg_idx_t REG_COS      = 3'd2;
  localparam reg_idx_t REG_SIN      = 3'd3;
  localparam reg_idx_t REG_TENSILE  = 3'd4;

  localparam int CFG_STRESS_W = 48;
  localparam int CFG_FACTOR_W = 32;

  localparam logic [CFG_FACTOR_W-1:0] SIN_RESET = 32'h4000_0000;

endpackage

// ===== src/mcfc_mul.sv =====
// Two-stage unsigned multiplier: four registered partial products, then a registered sum.
// Standalone; no package use.
module mcfc_mul #(
  parameter int AW = 48,
  parameter int BW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] p
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pp_ll_r;
  logic [AH+BL-1:0] pp_hl_r;
  logic [AL+BH-1:0] pp_lh_r;
  logic [AH+BH-1:0] pp_hh_r;
  logic [PW-1:0]    p_r;
  logic [PW-1:0]    p_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= a[AL-1:0] * b[BL-1:0];
      pp_hl_r <= a[AW-1:AL] * b[BL-1:0];
      pp_lh_r <= a[AL-1:0] * b[BW-1:BL];
      pp_hh_r <= a[AW-1:AL] * b[BW-1:BL];
      p_r     <= p_nxt;
    end
  end

  always_comb begin
    p_nxt = PW'(pp_ll_r)
          + (PW'(pp_hl_r) << AL)
          + (PW'(pp_lh_r) << BL)
          + (PW'(pp_hh_r) << (AL + BL));
  end

  assign p = p_r;

endmodule

// ===== src/mcfc_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a sideband carried alongside.
// Standalone; no package use. The sideband is cleared by reset so its valid bit starts clean.
module mcfc_isqrt #(
  parameter int RW = 48,
  parameter int SW = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   side_in,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  logic [RW:0]     rem_r  [0:RW-1];
  logic [RW-1:0]   root_r [0:RW-1];
  logic [2*RW-1:0] rad_r  [0:RW-1];
  logic [SW-1:0]   side_r [0:RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW:0]     rem_i;
    logic [RW-1:0]   root_i;
    logic [2*RW-1:0] rad_i;
    logic [SW-1:0]   side_i;
    logic [RW+2:0]   cur;
    logic [RW+2:0]   sub;
    logic            ge;
    logic [RW:0]     rem_nxt;
    logic [RW-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      cur      = {rem_i, rad_i[2*RW-1 -: 2]};
      sub      = {1'b0, root_i, 2'b01};
      ge       = (cur >= sub);
      rem_nxt  = ge ? (RW+1)'(cur - sub) : cur[RW:0];
      root_nxt = {root_i[RW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_i << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) side_r[k] <= '0;
      else if (en) side_r[k] <= side_i;
    end
  end

  assign root     = root_r[RW-1];
  assign side_out = side_r[RW-1];

endmodule

// ===== src/mohr_coulomb_failure_check_2d.sv =====
// Top level of the 2D Mohr-Coulomb failure check with tension cutoff.
// Uses mcfc_pkg, mcfc_mul and mcfc_isqrt.
//
// One stress word (sxx, syy, sxy plus the old broken mark) goes in, one flag word comes out,
// in order. The block is a fixed pipeline: a new word may enter every cycle while in_tready
// is high, and a word passes STRESS_WIDTH + 15 register stages. That count of stages is set
// by the square root, which resolves one root bit per stage (STRESS_WIDTH stages), plus
// three two-stage split multiplier steps and the add/saturate stages around them. The
// output register is backed by a skid stage, so in_tready only drops once both hold words;
// the whole pipe then freezes without losing or repeating anything. Registers sit on a
// 64-bit APB port at byte address 8*index (cohesion, slope, cos, sin, tensile); write them
// only while the pipe is empty.
module mohr_coulomb_failure_check_2d #(
  parameter int STRESS_WIDTH = 48
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: stress_xx, stress_yy, stress_xy (low to high), zero padded to bytes
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((3*STRESS_WIDTH+7)/8)*8-1:0]  in_tdata,
  // in_tuser: already_broken
  input  logic [0:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_tdata: broken, zero padded
  output logic [7:0]                           out_tdata,
  // out_tuser: shear_failure, tensile_failure (low to high)
  output logic [1:0]                           out_tuser,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [mcfc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [mcfc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [mcfc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  import mcfc_pkg::*;

  localparam int W    = STRESS_WIDTH;
  localparam int CMPW = ((W > CFG_STRESS_W) ? W : CFG_STRESS_W) + 2;
  localparam int PW   = W + CFG_FACTOR_W;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] x);
    logic signed [W-1:0] r;
    if (x[W] != x[W-1]) r = x[W] ? SMIN : SMAX;
    else r = x[W-1:0];
    return r;
  endfunction

  // ---------------- configuration registers ----------------
  logic [CFG_STRESS_W-1:0] coh_r, tens_r;
  logic [CFG_FACTOR_W-1:0] slope_r, rcos_r, rsin_r;
  reg_idx_t                cfg_idx;
  logic                    cfg_wr;

  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coh_r   <= '0;
      slope_r <= '0;
      rcos_r  <= '0;
      rsin_r  <= SIN_RESET;
      tens_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COHESION: coh_r   <= cfg_pwdata[CFG_STRESS_W-1:0];
        REG_SLOPE:    slope_r <= cfg_pwdata[CFG_FACTOR_W-1:0];
        REG_COS:      rcos_r  <= cfg_pwdata[CFG_FACTOR_W-1:0];
        REG_SIN:      rsin_r  <= cfg_pwdata[CFG_FACTOR_W-1:0];
        REG_TENSILE:  tens_r  <= cfg_pwdata[CFG_STRESS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COHESION: cfg_prdata = CFG_DATA_W'(coh_r);
      REG_SLOPE:    cfg_prdata = CFG_DATA_W'(slope_r);
      REG_COS:      cfg_prdata = CFG_DATA_W'(rcos_r);
      REG_SIN:      cfg_prdata = CFG_DATA_W'(rsin_r);
      REG_TENSILE:  cfg_prdata = CFG_DATA_W'(tens_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // magnitudes of the rotation factors (an out-of-range code is just its two's complement)
  logic [CFG_FACTOR_W-1:0] rsin_abs, rcos_abs;
  logic                    rcos_neg;
  assign rsin_abs = rsin_r[CFG_FACTOR_W-1] ? (~rsin_r + 1'b1) : rsin_r;
  assign rcos_abs = rcos_r[CFG_FACTOR_W-1] ? (~rcos_r + 1'b1) : rcos_r;
  assign rcos_neg = rcos_r[CFG_FACTOR_W-1];

  // ---------------- flow control ----------------
  // Pipe moves whenever the skid stage is free.
  logic skid_v_r, out_v_r, adv;
  assign adv       = !skid_v_r;
  assign in_tready = adv;

  // s0: captured word
  logic                s0_v_r, s0_prev_r;
  logic signed [W-1:0] s0_sx_r, s0_sy_r, s0_sxy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (adv) s0_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sx_r   <= in_tdata[W-1:0];
      s0_sy_r   <= in_tdata[2*W-1:W];
      s0_sxy_r  <= in_tdata[3*W-1:2*W];
      s0_prev_r <= in_tuser[0];
    end
  end

  // s1: difference magnitude, shear magnitude, mean (floor)
  logic signed [W:0]   s1_diff, s1_sum, s1_sxy_ext;
  logic [W-1:0]        s1_dxy_nxt, s1_asxy_nxt;
  logic                s1_v_r, s1_prev_r;
  logic [W-1:0]        s1_dxy_r, s1_asxy_r;
  logic signed [W-1:0] s1_mean_r;

  always_comb begin
    s1_diff     = {s0_sx_r[W-1], s0_sx_r} - {s0_sy_r[W-1], s0_sy_r};
    s1_sum      = {s0_sx_r[W-1], s0_sx_r} + {s0_sy_r[W-1], s0_sy_r};
    s1_sxy_ext  = {s0_sxy_r[W-1], s0_sxy_r};
    s1_dxy_nxt  = s1_diff[W] ? W'(-s1_diff) : s1_diff[W-1:0];
    s1_asxy_nxt = s1_sxy_ext[W] ? W'(-s1_sxy_ext) : s1_sxy_ext[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= s0_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dxy_r  <= s1_dxy_nxt;
      s1_asxy_r <= s1_asxy_nxt;
      s1_mean_r <= s1_sum[W:1];
      s1_prev_r <= s0_prev_r;
    end
  end

  // squares over two stages
  logic [2*W-1:0] sq_d, sq_s;
  mcfc_mul #(.AW(W), .BW(W)) u_sq_d (
    .clk(clk), .en(adv), .a(s1_dxy_r),  .b(s1_dxy_r),  .p(sq_d));
  mcfc_mul #(.AW(W), .BW(W)) u_sq_s (
    .clk(clk), .en(adv), .a(s1_asxy_r), .b(s1_asxy_r), .p(sq_s));

  logic                d1_v_r, d2_v_r, d1_prev_r, d2_prev_r;
  logic signed [W-1:0] d1_mean_r, d2_mean_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
    end else if (adv) begin
      d1_v_r <= s1_v_r;
      d2_v_r <= d1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_mean_r <= s1_mean_r;
      d2_mean_r <= d1_mean_r;
      d1_prev_r <= s1_prev_r;
      d2_prev_r <= d1_prev_r;
    end
  end

  // s3: radicand, below 2^(2W-1)
  logic                s3_v_r, s3_prev_r;
  logic [2*W-1:0]      s3_rad_r;
  logic signed [W-1:0] s3_mean_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= d2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_rad_r  <= (sq_d >> 2) + sq_s;
      s3_mean_r <= d2_mean_r;
      s3_prev_r <= d2_prev_r;
    end
  end

  // square root, W stages; valid, mean and old mark ride the sideband
  logic [W-1:0]        sq_root;
  logic [W+1:0]        sq_side;
  logic                r_v;
  logic                r_prev;
  logic signed [W-1:0] r_mean;

  mcfc_isqrt #(.RW(W), .SW(W+2)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(adv), .rad(s3_rad_r),
    .side_in({s3_v_r && rst_n, s3_prev_r, s3_mean_r}),
    .root(sq_root), .side_out(sq_side));

  assign r_v    = sq_side[W+1];
  assign r_prev = sq_side[W];
  assign r_mean = sq_side[W-1:0];

  // s4: principal stresses, spread and their average
  logic signed [W-1:0] s4_root_c, s4_p2_nxt, s4_p1_nxt;
  logic signed [W:0]   s4_spread_w, s4_avg_w;
  logic                s4_v_r, s4_prev_r;
  logic signed [W-1:0] s4_p2_r, s4_avg_r;
  logic [W-1:0]        s4_spread_r;

  always_comb begin
    s4_root_c   = sq_root[W-1] ? SMAX : sq_root;
    s4_p2_nxt   = sat_w({r_mean[W-1], r_mean} + {1'b0, s4_root_c});
    s4_p1_nxt   = sat_w({r_mean[W-1], r_mean} - {1'b0, s4_root_c});
    s4_spread_w = {s4_p2_nxt[W-1], s4_p2_nxt} - {s4_p1_nxt[W-1], s4_p1_nxt};
    s4_avg_w    = {s4_p2_nxt[W-1], s4_p2_nxt} + {s4_p1_nxt[W-1], s4_p1_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= r_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_p2_r     <= s4_p2_nxt;
      s4_spread_r <= s4_spread_w[W-1:0];
      s4_avg_r    <= s4_avg_w[W:1];
      s4_prev_r   <= r_prev;
    end
  end

  // rotation products
  logic [PW-1:0] pr_s, pr_c;
  mcfc_mul #(.AW(W), .BW(CFG_FACTOR_W)) u_mul_sin (
    .clk(clk), .en(adv), .a(s4_spread_r), .b(rsin_abs), .p(pr_s));
  mcfc_mul #(.AW(W), .BW(CFG_FACTOR_W)) u_mul_cos (
    .clk(clk), .en(adv), .a(s4_spread_r), .b(rcos_abs), .p(pr_c));

  logic                e1_v_r, e2_v_r, e1_prev_r, e2_prev_r;
  logic signed [W-1:0] e1_p2_r, e2_p2_r, e1_avg_r, e2_avg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
    end else if (adv) begin
      e1_v_r <= s4_v_r;
      e2_v_r <= e1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      e1_p2_r   <= s4_p2_r;
      e2_p2_r   <= e1_p2_r;
      e1_avg_r  <= s4_avg_r;
      e2_avg_r  <= e1_avg_r;
      e1_prev_r <= s4_prev_r;
      e2_prev_r <= e1_prev_r;
    end
  end

  // s5: shear (floor, saturated) and cos term (floor of a signed product)
  // cos term is -spread * cos / 2, so it is negative for a positive cos
  logic [W:0]          s5_qs;
  logic                s5_cneg;
  logic [W+1:0]        s5_qc;
  logic signed [W-1:0] s5_shear_nxt, s5_cterm_nxt;
  logic                s5_v_r, s5_prev_r;
  logic signed [W-1:0] s5_shear_r, s5_cterm_r, s5_p2_r, s5_avg_r;

  always_comb begin
    s5_qs        = pr_s[PW-1:31];
    s5_shear_nxt = (s5_qs[W] || s5_qs[W-1]) ? SMAX : s5_qs[W-1:0];
    s5_cneg      = !rcos_neg && (pr_c != '0);
    s5_qc        = {1'b0, pr_c[PW-1:31]} + (W+2)'(s5_cneg && (pr_c[30:0] != '0));
    if (!s5_cneg) begin
      s5_cterm_nxt = (s5_qc[W+1:W-1] != '0) ? SMAX : s5_qc[W-1:0];
    end else if ((s5_qc[W+1:W] != '0) || (s5_qc[W-1] && (s5_qc[W-2:0] != '0))) begin
      s5_cterm_nxt = SMIN;
    end else begin
      s5_cterm_nxt = W'(-s5_qc[W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= e2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_shear_r <= s5_shear_nxt;
      s5_cterm_r <= s5_cterm_nxt;
      s5_p2_r    <= e2_p2_r;
      s5_avg_r   <= e2_avg_r;
      s5_prev_r  <= e2_prev_r;
    end
  end

  // s6: normal stress on the rotated plane
  logic                s6_v_r, s6_prev_r;
  logic signed [W-1:0] s6_shear_r, s6_normal_r, s6_p2_r;
  logic [W-1:0]        s6_nabs;
  logic signed [W:0]   s6_nabs_w;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (adv) s6_v_r <= s5_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_normal_r <= sat_w({s5_avg_r[W-1], s5_avg_r} + {s5_cterm_r[W-1], s5_cterm_r});
      s6_shear_r  <= s5_shear_r;
      s6_p2_r     <= s5_p2_r;
      s6_prev_r   <= s5_prev_r;
    end
  end

  assign s6_nabs_w = {s6_normal_r[W-1], s6_normal_r};
  assign s6_nabs   = s6_nabs_w[W] ? W'(-s6_nabs_w) : s6_nabs_w[W-1:0];

  // friction product
  logic [PW-1:0] pr_f;
  mcfc_mul #(.AW(W), .BW(CFG_FACTOR_W)) u_mul_fric (
    .clk(clk), .en(adv), .a(s6_nabs), .b(slope_r), .p(pr_f));

  logic                f1_v_r, f2_v_r, f1_prev_r, f2_prev_r, f1_nneg_r, f2_nneg_r;
  logic signed [W-1:0] f1_shear_r, f2_shear_r, f1_p2_r, f2_p2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= s6_v_r;
      f2_v_r <= f1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_shear_r <= s6_shear_r;
      f2_shear_r <= f1_shear_r;
      f1_p2_r    <= s6_p2_r;
      f2_p2_r    <= f1_p2_r;
      f1_nneg_r  <= s6_normal_r[W-1];
      f2_nneg_r  <= f1_nneg_r;
      f1_prev_r  <= s6_prev_r;
      f2_prev_r  <= f1_prev_r;
    end
  end

  // s7: friction term, Q8.24 scale, floor and saturate
  logic                s7_fneg;
  logic [W+8:0]        s7_qf;
  logic signed [W-1:0] s7_fric_nxt;
  logic                s7_v_r, s7_prev_r, s7_nneg_r;
  logic signed [W-1:0] s7_fric_r, s7_shear_r, s7_p2_r;

  always_comb begin
    s7_fneg = f2_nneg_r && (pr_f != '0);
    s7_qf   = {1'b0, pr_f[PW-1:24]} + (W+9)'(s7_fneg && (pr_f[23:0] != '0));
    if (!s7_fneg) begin
      s7_fric_nxt = (s7_qf[W+8:W-1] != '0) ? SMAX : s7_qf[W-1:0];
    end else if ((s7_qf[W+8:W] != '0) || (s7_qf[W-1] && (s7_qf[W-2:0] != '0))) begin
      s7_fric_nxt = SMIN;
    end else begin
      s7_fric_nxt = W'(-s7_qf[W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (adv) s7_v_r <= f2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_fric_r  <= s7_fric_nxt;
      s7_shear_r <= f2_shear_r;
      s7_p2_r    <= f2_p2_r;
      s7_nneg_r  <= f2_nneg_r;
      s7_prev_r  <= f2_prev_r;
    end
  end

  // s8: shear limit |cohesion - friction| and tension cutoff compare
  logic signed [CMPW-1:0] s8_coh, s8_fric, s8_diff, s8_tens, s8_p2;
  logic signed [CMPW-1:0] s8_smax, s8_smin;
  logic signed [W-1:0]    s8_dsat;
  logic signed [W:0]      s8_dsat_w;
  logic [W-1:0]           s8_limit_nxt;
  logic                   s8_v_r, s8_prev_r, s8_nneg_r, s8_p2ge_r;
  logic [W-1:0]           s8_limit_r, s8_shear_r;

  always_comb begin
    s8_coh       = CMPW'(signed'(coh_r));
    s8_tens      = CMPW'(signed'(tens_r));
    s8_fric      = CMPW'(s7_fric_r);
    s8_p2        = CMPW'(s7_p2_r);
    s8_smax      = CMPW'(SMAX);
    s8_smin      = CMPW'(SMIN);
    s8_diff      = s8_coh - s8_fric;
    if (s8_diff > s8_smax) s8_dsat = SMAX;
    else if (s8_diff < s8_smin) s8_dsat = SMIN;
    else s8_dsat = s8_diff[W-1:0];
    s8_dsat_w    = {s8_dsat[W-1], s8_dsat};
    s8_limit_nxt = s8_dsat_w[W] ? W'(-s8_dsat_w) : s8_dsat_w[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else if (adv) s8_v_r <= s7_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_limit_r <= s8_limit_nxt;
      s8_shear_r <= s7_shear_r;
      s8_nneg_r  <= s7_nneg_r;
      s8_p2ge_r  <= (s8_p2 >= s8_tens);
      s8_prev_r  <= s7_prev_r;
    end
  end

  // final decision
  logic       fin_v, fin_sf, fin_tf;
  logic [2:0] fin_flags;
  assign fin_v     = s8_v_r && adv;
  assign fin_sf    = (s8_shear_r >= s8_limit_r) && s8_nneg_r;
  assign fin_tf    = !fin_sf && s8_p2ge_r;
  assign fin_flags = {fin_tf, fin_sf, s8_prev_r || fin_sf || fin_tf};

  // output register plus skid stage
  logic [2:0] out_flags_r, skid_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= fin_v;
      end
    end else if (fin_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_flags_r <= skid_v_r ? skid_flags_r : fin_flags;
    end else if (fin_v) begin
      skid_flags_r <= fin_flags;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_flags_r[0]};
  assign out_tuser  = out_flags_r[2:1];

  // ---------------- checks ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid stage full while output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid stage filled without an output stall");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("shear and tensile failure both set");

  a_broken_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] || out_tuser[1])) |-> out_tdata[0])
    else $error("failure reported without broken mark");

endmodule
